@@ sv/ntu_pkg.sv @@
// Shared types and constants for the neighbour table update block.
package ntu_pkg;

	// Widths fixed by the channel payloads
	localparam int unsigned MAC_IN_W = 48;
	localparam int unsigned COORD_IN_W = 16;
	localparam int unsigned TICK_W = 32;
	localparam int unsigned RANGE_W = 33;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned SLOT_W = 3;

	localparam logic [RANGE_W-1:0] RANGE_RESET = 33'd10000;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;    // capture an accepted item
		logic square;  // square the distances, search the table
		logic commit;  // decide, update the table, load the result
	} ntu_cmd_t;

endpackage

@@ sv/ntu_if.sv @@
// Channel interfaces: hello events in, results out, range register writes.
interface ntu_evt_if;
	import ntu_pkg::*;
	logic valid;
	logic ready;
	logic [MAC_IN_W-1:0] sender_mac;
	logic [COORD_IN_W-1:0] sender_x;
	logic [COORD_IN_W-1:0] sender_y;
	logic [COORD_IN_W-1:0] own_x;
	logic [COORD_IN_W-1:0] own_y;
	logic [TICK_W-1:0] now;
	logic sender_enabled;
	logic own_enabled;
	logic sender_sending;
	logic own_listening;
	logic is_hello;

	modport source(output valid, sender_mac, sender_x, sender_y, own_x, own_y, now,
		sender_enabled, own_enabled, sender_sending, own_listening, is_hello,
		input ready);
	modport sink(input valid, sender_mac, sender_x, sender_y, own_x, own_y, now,
		sender_enabled, own_enabled, sender_sending, own_listening, is_hello,
		output ready);
endinterface

interface ntu_res_if;
	import ntu_pkg::*;
	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0] slot;

	modport source(output valid, status, slot, input ready);
	modport sink(input valid, status, slot, output ready);
endinterface

interface ntu_cfg_if;
	import ntu_pkg::*;
	logic valid;
	logic ready;
	logic [RANGE_W-1:0] range_squared;

	modport source(output valid, range_squared, input ready);
	modport sink(input valid, range_squared, output ready);
endinterface

@@ sv/ntu_ctrl.sv @@
// Controller: sequences one item through capture, square/search and commit.
module ntu_ctrl
	import ntu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output ntu_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SQ = 2'd1;
	localparam logic [1:0] S_UPD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic out_valid_q;
	logic accept;
	logic commit;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	// Commit only once the result register is free or being emptied
	assign commit = (state_q == S_UPD) && (!out_valid_q || out_ready);

	assign cmd.load = accept;
	assign cmd.square = (state_q == S_SQ);
	assign cmd.commit = commit;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_SQ;
			end
			S_SQ: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				if (commit) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/ntu_dp.sv @@
// Datapath: distance test, neighbour table, match/free search and result register.
module ntu_dp
	import ntu_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int COORD_BITS = 16,
	parameter int MAC_BYTES = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ntu_cmd_t              cmd,
	input  logic                  cfg_valid,
	input  logic [RANGE_W-1:0]    cfg_data,
	input  logic [MAC_IN_W-1:0]   sender_mac,
	input  logic [COORD_IN_W-1:0] sender_x,
	input  logic [COORD_IN_W-1:0] sender_y,
	input  logic [COORD_IN_W-1:0] own_x,
	input  logic [COORD_IN_W-1:0] own_y,
	input  logic [TICK_W-1:0]     now,
	input  logic                  sender_enabled,
	input  logic                  own_enabled,
	input  logic                  sender_sending,
	input  logic                  own_listening,
	input  logic                  is_hello,
	output logic [STATUS_W-1:0]   status,
	output logic [SLOT_W-1:0]     slot
);

	localparam int CW = (COORD_BITS < COORD_IN_W) ? COORD_BITS : COORD_IN_W;
	localparam int MW = (8 * MAC_BYTES < MAC_IN_W) ? 8 * MAC_BYTES : MAC_IN_W;
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SW = 2 * CW + 1;

	// Range register
	logic [RANGE_W-1:0] range_q;

	// Neighbour table
	logic [MW-1:0] mac_q [SLOTS];
	logic [TICK_W-1:0] first_q [SLOTS];
	logic [TICK_W-1:0] last_q [SLOTS];

	// Stage 1: captured item
	logic [CW-1:0] dx_s1;
	logic [CW-1:0] dy_s1;
	logic [MW-1:0] mac_s1;
	logic [TICK_W-1:0] now_s1;
	logic active_s1;
	logic hello_s1;

	// Stage 2: squares and table search
	logic [2*CW-1:0] dx2_s2;
	logic [2*CW-1:0] dy2_s2;
	logic hit_s2;
	logic [IW-1:0] hit_idx_s2;
	logic free_s2;
	logic [IW-1:0] free_idx_s2;

	// Result register
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0] slot_q;

	logic [CW-1:0] ax, bx, ay, by;
	logic hit_c, free_c;
	logic [IW-1:0] hit_idx_c, free_idx_c;
	logic [SW-1:0] dist_sq;
	logic in_range;
	logic [STATUS_W-1:0] status_d;
	logic [SLOT_W-1:0] slot_d;
	logic wr_ins;
	logic wr_ref;

	assign ax = sender_x[CW-1:0];
	assign bx = own_x[CW-1:0];
	assign ay = sender_y[CW-1:0];
	assign by = own_y[CW-1:0];

	// Write the range register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= RANGE_RESET;
		end else if (cfg_valid) begin
			range_q <= cfg_data;
		end
	end

	// Capture the item with absolute coordinate differences
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_s1 <= (ax > bx) ? (ax - bx) : (bx - ax);
			dy_s1 <= (ay > by) ? (ay - by) : (by - ay);
			mac_s1 <= sender_mac[MW-1:0];
			now_s1 <= now;
			active_s1 <= sender_enabled && own_enabled && sender_sending && own_listening;
			hello_s1 <= is_hello;
		end
	end

	// Find the lowest occupied matching slot and the lowest free slot
	always_comb begin
		hit_c = 1'b0;
		free_c = 1'b0;
		hit_idx_c = '0;
		free_idx_c = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (first_q[i] != '0 && mac_q[i] == mac_s1) begin
				hit_c = 1'b1;
				hit_idx_c = IW'(i);
			end
			if (first_q[i] == '0) begin
				free_c = 1'b1;
				free_idx_c = IW'(i);
			end
		end
	end

	// Square the differences, register the search
	always_ff @(posedge clk) begin
		if (cmd.square) begin
			dx2_s2 <= {{CW{1'b0}}, dx_s1} * {{CW{1'b0}}, dx_s1};
			dy2_s2 <= {{CW{1'b0}}, dy_s1} * {{CW{1'b0}}, dy_s1};
			hit_s2 <= hit_c;
			hit_idx_s2 <= hit_idx_c;
			free_s2 <= free_c;
			free_idx_s2 <= free_idx_c;
		end
	end

	// Decide the outcome
	assign dist_sq = {1'b0, dx2_s2} + {1'b0, dy2_s2};
	assign in_range = RANGE_W'(dist_sq) < range_q;

	always_comb begin
		status_d = ST_IGNORED;
		slot_d = '0;
		wr_ins = 1'b0;
		wr_ref = 1'b0;
		if (active_s1 && in_range) begin
			if (!hello_s1) begin
				status_d = ST_INVALID;
			end else if (hit_s2) begin
				status_d = ST_REFRESHED;
				slot_d = SLOT_W'(hit_idx_s2);
				wr_ref = 1'b1;
			end else if (free_s2) begin
				status_d = ST_INSERTED;
				slot_d = SLOT_W'(free_idx_s2);
				wr_ins = 1'b1;
			end else begin
				status_d = ST_FULL;
			end
		end
	end

	// Update seen ticks; a cleared first-seen marks a free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				first_q[i] <= '0;
				last_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			if (wr_ins) begin
				first_q[free_idx_s2] <= now_s1;
				last_q[free_idx_s2] <= now_s1;
			end else if (wr_ref) begin
				last_q[hit_idx_s2] <= now_s1;
			end
		end
	end

	// Store the MAC of a new neighbour
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_ins) begin
			mac_q[free_idx_s2] <= mac_s1;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= status_d;
			slot_q <= slot_d;
		end
	end

	assign status = status_q;
	assign slot = slot_q;

endmodule

@@ sv/neighbour_table_update.sv @@
// Top level of the neighbour table update block.
// One hello event is taken at a time and passes through capture with the
// coordinate differences, the two squarers with the parallel table match and
// free-slot search, then the range test and the table write-back, which also
// loads the result register. The next event is taken in the cycle after
// write-back, while the result may still wait to be taken; write-back
// stalls only if an earlier result is still waiting. The table is empty right
// after reset (all slots free), with no clearing pass. Range writes are taken
// in any cycle and apply from the next range test, so write the range only
// while no event is in flight.
module neighbour_table_update
	import ntu_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int COORD_BITS = 16,
	parameter int MAC_BYTES = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	ntu_evt_if.sink       evt,
	ntu_res_if.source     res,
	ntu_cfg_if.sink       cfg
);

	ntu_cmd_t cmd;

	// Range register writes are always taken
	assign cfg.ready = 1'b1;

	ntu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (evt.valid),
		.in_ready (evt.ready),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.cmd      (cmd)
	);

	ntu_dp #(
		.SLOTS     (SLOTS),
		.COORD_BITS(COORD_BITS),
		.MAC_BYTES (MAC_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_valid     (cfg.valid),
		.cfg_data      (cfg.range_squared),
		.sender_mac    (evt.sender_mac),
		.sender_x      (evt.sender_x),
		.sender_y      (evt.sender_y),
		.own_x         (evt.own_x),
		.own_y         (evt.own_y),
		.now           (evt.now),
		.sender_enabled(evt.sender_enabled),
		.own_enabled   (evt.own_enabled),
		.sender_sending(evt.sender_sending),
		.own_listening (evt.own_listening),
		.is_hello      (evt.is_hello),
		.status        (res.status),
		.slot          (res.slot)
	);

endmodule

@@ bench/tb_neighbour_table_update.sv @@
// Self-checking testbench for the neighbour table update block.
`timescale 1ns / 1ps

module tb_neighbour_table_update;
	import ntu_pkg::*;

	localparam int NSLOTS = 8;
	localparam int COORD_MAX = 65535;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// One hello event as offered on the event channel
	typedef struct {
		logic [MAC_IN_W-1:0] mac;
		logic [COORD_IN_W-1:0] sx;
		logic [COORD_IN_W-1:0] sy;
		logic [COORD_IN_W-1:0] ox;
		logic [COORD_IN_W-1:0] oy;
		logic [TICK_W-1:0] now;
		logic s_en;
		logic o_en;
		logic s_tx;
		logic o_rx;
		logic hello;
	} hello_t;

	// What the block should answer for one event
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0] slot;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;

	ntu_evt_if evt_ch();
	ntu_res_if res_ch();
	ntu_cfg_if cfg_ch();

	neighbour_table_update DUT (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	// Own copy of the neighbour table and the range register
	logic [RANGE_W-1:0] range_now;
	logic [MAC_IN_W-1:0] slot_mac [NSLOTS];
	logic [TICK_W-1:0] tbl_first [NSLOTS];
	logic [TICK_W-1:0] tbl_last [NSLOTS];

	hello_t pending_hellos [$];
	verdict_t due_verdicts [$];
	hello_t on_wire;
	int unsigned queued_total = 0;
	int unsigned taken_total = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit quiet = 1'b0;

	// MACs that end up in the table, in slot order
	logic [MAC_IN_W-1:0] known_mac [NSLOTS];
	logic [MAC_IN_W-1:0] ghost_mac;

	always #2 clk = ~clk;

	// Apply one event to the table copy and return the expected answer
	function automatic verdict_t update_table(hello_t h);
		verdict_t v;
		longint unsigned dx;
		longint unsigned dy;
		longint unsigned dist_sq;
		bit done;
		int i;
		v.status = ST_IGNORED;
		v.slot = '0;
		done = 1'b0;
		if (h.s_en && h.o_en && h.s_tx && h.o_rx) begin
			dx = (h.sx > h.ox) ? longint'(h.sx - h.ox) : longint'(h.ox - h.sx);
			dy = (h.sy > h.oy) ? longint'(h.sy - h.oy) : longint'(h.oy - h.sy);
			dist_sq = dx * dx + dy * dy;
			if (dist_sq < longint'(range_now)) begin
				if (!h.hello) begin
					v.status = ST_INVALID;
				end else begin
					// refresh the lowest occupied slot holding this MAC
					for (i = 0; i < NSLOTS; i++) begin
						if (!done && tbl_first[i] != 0 && slot_mac[i] == h.mac) begin
							tbl_last[i] = h.now;
							v.status = ST_REFRESHED;
							v.slot = SLOT_W'(i);
							done = 1'b1;
						end
					end
					// otherwise take the lowest free slot
					if (!done) begin
						v.status = ST_FULL;
						for (i = 0; i < NSLOTS; i++) begin
							if (!done && tbl_first[i] == 0) begin
								slot_mac[i] = h.mac;
								tbl_first[i] = h.now;
								tbl_last[i] = h.now;
								v.status = ST_INSERTED;
								v.slot = SLOT_W'(i);
								done = 1'b1;
							end
						end
					end
				end
			end
		end
		return v;
	endfunction

	// Largest offset whose square still lies strictly inside the range
	function automatic int unsigned reach_of(logic [RANGE_W-1:0] r);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		lo = 0;
		hi = COORD_MAX;
		if (r == 0)
			return 0;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid < longint'(r))
				lo = mid;
			else
				hi = mid - 1;
		end
		return int'(lo);
	endfunction

	// Well-formed hello with the sender at the given offsets from the receiver
	function automatic hello_t aimed(logic [MAC_IN_W-1:0] mac, logic [TICK_W-1:0] now,
			int unsigned dx, int unsigned dy);
		hello_t h;
		h.mac = mac;
		h.now = now;
		h.s_en = 1'b1;
		h.o_en = 1'b1;
		h.s_tx = 1'b1;
		h.o_rx = 1'b1;
		h.hello = 1'b1;
		if ($urandom_range(0, 1)) begin
			h.ox = COORD_IN_W'($urandom_range(0, COORD_MAX - dx));
			h.sx = h.ox + COORD_IN_W'(dx);
		end else begin
			h.ox = COORD_IN_W'($urandom_range(dx, COORD_MAX));
			h.sx = h.ox - COORD_IN_W'(dx);
		end
		if ($urandom_range(0, 1)) begin
			h.oy = COORD_IN_W'($urandom_range(0, COORD_MAX - dy));
			h.sy = h.oy + COORD_IN_W'(dy);
		end else begin
			h.oy = COORD_IN_W'($urandom_range(dy, COORD_MAX));
			h.sy = h.oy - COORD_IN_W'(dy);
		end
		return h;
	endfunction

	// Mostly in-range hellos from known neighbours, the rest noise
	function automatic hello_t random_hello(logic [RANGE_W-1:0] r);
		hello_t h;
		logic [MAC_IN_W-1:0] mac;
		logic [TICK_W-1:0] now;
		int unsigned reach;
		int unsigned dx;
		int unsigned dy;
		int unsigned pick;
		reach = reach_of(r);
		dx = $urandom_range(0, reach + reach / 8 + 1);
		dy = $urandom_range(0, (reach + 1) / 3);
		if (dx > COORD_MAX)
			dx = COORD_MAX;
		now = TICK_W'($urandom);
		if (now == 0)
			now = 1;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			mac = known_mac[$urandom_range(0, NSLOTS - 1)];
		else if (pick < 80)
			mac = known_mac[$urandom_range(0, NSLOTS - 1)] ^ (48'h1 << $urandom_range(0, 47));
		else
			mac = {16'($urandom), 32'($urandom)};
		h = aimed(mac, now, dx, dy);
		if ($urandom_range(0, 99) < 25) begin
			// noise: any flags, anywhere on the map
			h.sx = COORD_IN_W'($urandom);
			h.sy = COORD_IN_W'($urandom);
			h.ox = COORD_IN_W'($urandom);
			h.oy = COORD_IN_W'($urandom);
			h.s_en = 1'($urandom);
			h.o_en = 1'($urandom);
			h.s_tx = 1'($urandom);
			h.o_rx = 1'($urandom);
			h.hello = 1'($urandom);
		end else begin
			h.hello = ($urandom_range(0, 9) != 0);
		end
		return h;
	endfunction

	task automatic queue_hello(hello_t h);
		pending_hellos.push_back(h);
		queued_total++;
	endtask

	// Hold until every queued item is taken and answered
	task automatic drain();
		while (taken_total != queued_total || due_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_range(logic [RANGE_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.range_squared <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		range_now = value;
	endtask

	task automatic random_phase(logic [RANGE_W-1:0] r, int count, bit steady);
		int n;
		write_range(r);
		quiet = steady;
		for (n = 0; n < count; n++)
			queue_hello(random_hello(r));
		drain();
		quiet = 1'b0;
	endtask

	// Driver: offer pending items, predict each one as it is accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			evt_ch.valid <= 1'b0;
		end else begin
			if (evt_ch.valid && evt_ch.ready) begin
				due_verdicts.push_back(update_table(on_wire));
				taken_total++;
			end
			if (!evt_ch.valid || evt_ch.ready) begin
				if (pending_hellos.size() != 0 && (quiet || $urandom_range(0, 99) >= 26)) begin
					on_wire = pending_hellos.pop_front();
					evt_ch.valid <= 1'b1;
					evt_ch.sender_mac <= on_wire.mac;
					evt_ch.sender_x <= on_wire.sx;
					evt_ch.sender_y <= on_wire.sy;
					evt_ch.own_x <= on_wire.ox;
					evt_ch.own_y <= on_wire.oy;
					evt_ch.now <= on_wire.now;
					evt_ch.sender_enabled <= on_wire.s_en;
					evt_ch.own_enabled <= on_wire.o_en;
					evt_ch.sender_sending <= on_wire.s_tx;
					evt_ch.own_listening <= on_wire.o_rx;
					evt_ch.is_hello <= on_wire.hello;
				end else begin
					evt_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		verdict_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (due_verdicts.size() == 0) begin
					$error("unexpected result: status %0d slot %0d", res_ch.status, res_ch.slot);
					mismatches++;
				end else begin
					want = due_verdicts.pop_front();
					if (res_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res_ch.status);
						mismatches++;
					end
					if (res_ch.slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, res_ch.slot);
						mismatches++;
					end
				end
			end
			res_ch.ready <= quiet || ($urandom_range(0, 99) >= 26);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_neighbour_table_update NOT OK");
			$finish;
		end
	end

	initial begin
		hello_t h;
		int k;
		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.sender_mac = '0;
		evt_ch.sender_x = '0;
		evt_ch.sender_y = '0;
		evt_ch.own_x = '0;
		evt_ch.own_y = '0;
		evt_ch.now = '0;
		evt_ch.sender_enabled = 1'b0;
		evt_ch.own_enabled = 1'b0;
		evt_ch.sender_sending = 1'b0;
		evt_ch.own_listening = 1'b0;
		evt_ch.is_hello = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.range_squared = '0;
		range_now = RANGE_RESET;
		for (k = 0; k < NSLOTS; k++) begin
			slot_mac[k] = '0;
			tbl_first[k] = '0;
			tbl_last[k] = '0;
		end
		known_mac[0] = '1;
		known_mac[1] = '0;
		for (k = 2; k < NSLOTS; k++)
			known_mac[k] = {16'($urandom), 32'($urandom)};
		ghost_mac = 48'h0123_4567_89AB;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items at the reset range
		queue_hello(aimed(known_mac[0], 32'hFFFF_FFFF, 3, 4));
		queue_hello(aimed(known_mac[0], 32'd7, 0, 0));
		// all-zero MAC, both nodes at the origin, earliest tick
		h = aimed(known_mac[1], 32'd1, 0, 0);
		h.sx = '0;
		h.sy = '0;
		h.ox = '0;
		h.oy = '0;
		queue_hello(h);
		// insertion at tick zero leaves the slot free
		queue_hello(aimed(ghost_mac, 32'd0, 1, 1));
		queue_hello(aimed(known_mac[2], 32'd100, 60, 79));
		// far corner, just inside the range
		h = aimed(known_mac[3], 32'd200, 0, 0);
		h.ox = 16'hFFFF;
		h.oy = 16'hFFFF;
		h.sx = 16'hFFFF - 16'd99;
		h.sy = 16'hFFFF - 16'd14;
		queue_hello(h);
		for (k = 4; k < NSLOTS; k++)
			queue_hello(aimed(known_mac[k], TICK_W'(300 + k), $urandom_range(0, 60),
				$urandom_range(0, 60)));
		// table full: new MAC, and a MAC one bit away from a stored one
		queue_hello(aimed(ghost_mac, 32'd5, 0, 0));
		queue_hello(aimed(known_mac[0] ^ 48'h1, 32'd9, 2, 2));
		queue_hello(aimed(known_mac[7], 32'h8000_0000, 0, 0));
		h = aimed(known_mac[5], 32'd10, 5, 5);
		h.hello = 1'b0;
		queue_hello(h);
		// distance equal to the range, and opposite corners
		queue_hello(aimed(known_mac[5], 32'd11, 100, 0));
		h = aimed(known_mac[6], 32'd12, 0, 0);
		h.ox = '0;
		h.oy = '0;
		h.sx = '1;
		h.sy = '1;
		queue_hello(h);
		// one activity flag low at a time
		for (k = 0; k < 4; k++) begin
			h = aimed(known_mac[k], 32'd13, 1, 1);
			h.s_en = (k != 0);
			h.o_en = (k != 1);
			h.s_tx = (k != 2);
			h.o_rx = (k != 3);
			queue_hello(h);
		end
		drain();

		// Random phases across range settings
		random_phase('0, 60, 1'b0);
		random_phase('1, 300, 1'b1);
		random_phase(33'd2000, 250, 1'b0);
		random_phase({1'($urandom), 32'($urandom)}, 250, 1'b0);
		random_phase(33'h1_0000_0000, 150, 1'b0);
		random_phase(33'd1, 140, 1'b0);

		repeat (10) @(posedge clk);
		if (mismatches == 0 && due_verdicts.size() == 0) begin
			$display("tb_neighbour_table_update OK");
		end else begin
			$display("tb_neighbour_table_update NOT OK");
		end
		$finish;
	end

endmodule
